[hw/rtl/dpid_pkg.sv]
// Shared types, widths and constants for the dual PID wheel speed controller.
package dpid_pkg;

	localparam int STEP_MS = 100;
	localparam int STEP_W  = $clog2(STEP_MS + 1);

	localparam int SPEED_W     = 16;
	localparam int HEAD_W      = 9;
	localparam int GOAL_W      = 9;
	localparam int RATE_W      = 12;
	localparam int RATE_ERR_W  = RATE_W + 1;
	localparam int ANGLE_ERR_W = 10;
	localparam int INTEG_W     = 17;
	localparam int DRIVE_W     = 32;

	localparam int KP_W    = 15;
	localparam int KI_W    = 15;
	localparam int KD_W    = 20;
	localparam int LIM_W   = 16;
	localparam int MAXS_W  = 15;
	localparam int CFG_W   = 20;
	localparam int CFG_IDX_W = 3;

	localparam int HALF_TURN = 180;
	localparam int FULL_TURN = 360;

	localparam logic [KP_W-1:0]   RATE_KP_RST  = KP_W'(2560);
	localparam logic [KI_W-1:0]   RATE_KI_RST  = KI_W'(256);
	localparam logic [KD_W-1:0]   RATE_KD_RST  = KD_W'(1049);
	localparam logic [KP_W-1:0]   ANGLE_KP_RST = KP_W'(384);
	localparam logic [KI_W-1:0]   ANGLE_KI_RST = KI_W'(640);
	localparam logic [KD_W-1:0]   ANGLE_KD_RST = KD_W'(1573);
	localparam logic [LIM_W-1:0]  INTEG_LIM_RST = LIM_W'(10);
	localparam logic [MAXS_W-1:0] MAX_SPEED_RST = MAXS_W'(3000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RATE_KP  = 3'd0,
		REG_RATE_KI  = 3'd1,
		REG_RATE_KD  = 3'd2,
		REG_ANGLE_KP = 3'd3,
		REG_ANGLE_KI = 3'd4,
		REG_ANGLE_KD = 3'd5,
		REG_INTEG_LIM = 3'd6,
		REG_MAX_SPEED = 3'd7
	} cfg_reg_t;

	// stage load strobes shared by the top level and the loop units
	typedef struct packed {
		logic ld2;
		logic ld3;
		logic ld4;
	} stage_ld_t;

endpackage

[hw/rtl/dpid_loop.sv]
// One PID loop: clamped integrator, previous-error derivative, saturated drive.
module dpid_loop #(
	parameter int E_W = dpid_pkg::RATE_ERR_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dpid_pkg::stage_ld_t               ld,
	input  logic signed [E_W-1:0]             err,
	input  logic [dpid_pkg::KP_W-1:0]         kp,
	input  logic [dpid_pkg::KI_W-1:0]         ki,
	input  logic [dpid_pkg::KD_W-1:0]         kd,
	input  logic [dpid_pkg::LIM_W-1:0]        integ_limit,
	output logic signed [dpid_pkg::DRIVE_W-1:0] drive
);

	localparam int IW    = dpid_pkg::INTEG_W;
	localparam int MS_W  = E_W + dpid_pkg::STEP_W + 1;
	localparam int ACC_W = ((MS_W > IW) ? MS_W : IW) + 1;
	localparam int DF_W  = E_W + 1;
	localparam int P_W   = E_W + dpid_pkg::KP_W + 1;
	localparam int I_W   = IW + dpid_pkg::KI_W + 1;
	localparam int D_W   = DF_W + dpid_pkg::KD_W + 1;
	localparam int S_W   = 36;
	localparam int DW    = dpid_pkg::DRIVE_W;

	localparam logic signed [MS_W-1:0] STEP_S = MS_W'(dpid_pkg::STEP_MS);
	localparam logic signed [D_W:0]    D_HALF = (D_W+1)'(2048);
	localparam logic signed [S_W-1:0]  S_MAX  = S_W'(32'sh7FFF_FFFF);
	localparam logic signed [S_W-1:0]  S_MIN  = S_W'(32'sh8000_0000);

	logic signed [E_W-1:0]  prev_q;
	logic signed [IW-1:0]   integ_q;

	logic signed [MS_W-1:0]  e_ms;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] lim_s;
	logic signed [IW-1:0]    integ_nx;

	logic signed [E_W-1:0]  err_s2;
	logic signed [DF_W-1:0] diff_s2;
	logic signed [IW-1:0]   integ_s2;

	logic signed [P_W-1:0] p_s3;
	logic signed [I_W-1:0] i_s3;
	logic signed [D_W-1:0] d_s3;

	logic signed [D_W:0]   d_rnd;
	logic signed [S_W-1:0] sum;

	assign e_ms  = MS_W'(err) * STEP_S;
	assign acc   = ACC_W'(integ_q) + ACC_W'(e_ms);
	assign lim_s = ACC_W'({1'b0, integ_limit});

	always_comb begin
		if (acc > lim_s) begin
			integ_nx = IW'(lim_s);
		end else if (acc < -lim_s) begin
			integ_nx = IW'(-lim_s);
		end else begin
			integ_nx = IW'(acc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			integ_q <= '0;
		end else if (ld.ld2) begin
			prev_q  <= err;
			integ_q <= integ_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.ld2) begin
			err_s2   <= err;
			diff_s2  <= DF_W'(err) - DF_W'(prev_q);
			integ_s2 <= integ_nx;
		end
		if (ld.ld3) begin
			p_s3 <= $signed({1'b0, kp}) * err_s2;
			i_s3 <= $signed({1'b0, ki}) * integ_s2;
			d_s3 <= $signed({1'b0, kd}) * diff_s2;
		end
	end

	// derivative rounds to nearest, ties upward
	assign d_rnd = (D_W+1)'(d_s3) + D_HALF;
	assign sum   = S_W'(p_s3) + S_W'(i_s3) + S_W'(d_rnd >>> 12);

	always_ff @(posedge clk) begin
		if (ld.ld4) begin
			if (sum > S_MAX) begin
				drive <= DW'(S_MAX);
			end else if (sum < S_MIN) begin
				drive <= DW'(S_MIN);
			end else begin
				drive <= DW'(sum);
			end
		end
	end

endmodule

[hw/rtl/dual_pid_wheel_speed_control.sv]
// Top level of the dual PID wheel speed controller: config, pipeline, speed clamp.
//
//   channel | handshake             | payload
//   --------+-----------------------+-----------------------------------------------
//   in      | in_valid / in_ready   | motor_speed, heading, heading_goal, body_rate,
//           |                       | rate_goal
//   out     | out_valid / out_ready | new_motor_speed, speed_limited, rate_drive,
//           |                       | angle_drive
//   cfg     | cfg_we                | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled.
// Five register stages: input, error/integrator, products, drives, output.
// Integrator and previous-error state advance as an item leaves the input stage.
// A stalled output backs up stage by stage; each stage fills when it is empty or the one ahead moves.
// Reset restores register defaults and clears loop state and all valid flags.
module dual_pid_wheel_speed_control (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [dpid_pkg::SPEED_W-1:0]    motor_speed,
	input  logic signed [dpid_pkg::HEAD_W-1:0]     heading,
	input  logic [dpid_pkg::GOAL_W-1:0]            heading_goal,
	input  logic signed [dpid_pkg::RATE_W-1:0]     body_rate,
	input  logic signed [dpid_pkg::RATE_W-1:0]     rate_goal,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [dpid_pkg::SPEED_W-1:0]    new_motor_speed,
	output logic                                   speed_limited,
	output logic signed [dpid_pkg::DRIVE_W-1:0]    rate_drive,
	output logic signed [dpid_pkg::DRIVE_W-1:0]    angle_drive,
	input  logic                                   cfg_we,
	input  logic [dpid_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dpid_pkg::CFG_W-1:0]             cfg_data
);

	localparam int SW  = dpid_pkg::SPEED_W;
	localparam int DW  = dpid_pkg::DRIVE_W;
	localparam int X_W = DW + 2;
	localparam int Q_W = X_W - 8;
	localparam int HW  = 12;

	// configuration
	logic [dpid_pkg::KP_W-1:0]   rate_kp_q, angle_kp_q;
	logic [dpid_pkg::KI_W-1:0]   rate_ki_q, angle_ki_q;
	logic [dpid_pkg::KD_W-1:0]   rate_kd_q, angle_kd_q;
	logic [dpid_pkg::LIM_W-1:0]  integ_lim_q;
	logic [dpid_pkg::MAXS_W-1:0] max_speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_kp_q   <= dpid_pkg::RATE_KP_RST;
			rate_ki_q   <= dpid_pkg::RATE_KI_RST;
			rate_kd_q   <= dpid_pkg::RATE_KD_RST;
			angle_kp_q  <= dpid_pkg::ANGLE_KP_RST;
			angle_ki_q  <= dpid_pkg::ANGLE_KI_RST;
			angle_kd_q  <= dpid_pkg::ANGLE_KD_RST;
			integ_lim_q <= dpid_pkg::INTEG_LIM_RST;
			max_speed_q <= dpid_pkg::MAX_SPEED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dpid_pkg::REG_RATE_KP:   rate_kp_q   <= cfg_data[dpid_pkg::KP_W-1:0];
				dpid_pkg::REG_RATE_KI:   rate_ki_q   <= cfg_data[dpid_pkg::KI_W-1:0];
				dpid_pkg::REG_RATE_KD:   rate_kd_q   <= cfg_data[dpid_pkg::KD_W-1:0];
				dpid_pkg::REG_ANGLE_KP:  angle_kp_q  <= cfg_data[dpid_pkg::KP_W-1:0];
				dpid_pkg::REG_ANGLE_KI:  angle_ki_q  <= cfg_data[dpid_pkg::KI_W-1:0];
				dpid_pkg::REG_ANGLE_KD:  angle_kd_q  <= cfg_data[dpid_pkg::KD_W-1:0];
				dpid_pkg::REG_INTEG_LIM: integ_lim_q <= cfg_data[dpid_pkg::LIM_W-1:0];
				dpid_pkg::REG_MAX_SPEED: max_speed_q <= cfg_data[dpid_pkg::MAXS_W-1:0];
			endcase
		end
	end

	// pipeline flow control
	logic v1_q, v2_q, v3_q, v4_q;
	logic rdy2, rdy3, rdy4, rdy_out;
	dpid_pkg::stage_ld_t ld;
	logic ld1, ld_out;

	assign rdy_out  = !out_valid || out_ready;
	assign rdy4     = !v4_q || rdy_out;
	assign rdy3     = !v3_q || rdy4;
	assign rdy2     = !v2_q || rdy3;
	assign in_ready = !v1_q || rdy2;
	assign ld1      = in_valid && in_ready;
	assign ld.ld2   = v1_q && rdy2;
	assign ld.ld3   = v2_q && rdy3;
	assign ld.ld4   = v3_q && rdy4;
	assign ld_out   = v4_q && rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q      <= 1'b0;
			v2_q      <= 1'b0;
			v3_q      <= 1'b0;
			v4_q      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_ready) begin
				v1_q <= in_valid;
			end
			if (rdy2) begin
				v2_q <= v1_q;
			end
			if (rdy3) begin
				v3_q <= v2_q;
			end
			if (rdy4) begin
				v4_q <= v3_q;
			end
			if (rdy_out) begin
				out_valid <= v4_q;
			end
		end
	end

	// input stage
	logic signed [SW-1:0]                  speed_s1, speed_s2, speed_s3, speed_s4;
	logic signed [dpid_pkg::HEAD_W-1:0]    head_s1;
	logic [dpid_pkg::GOAL_W-1:0]           goal_s1;
	logic signed [dpid_pkg::RATE_W-1:0]    rate_s1, rgoal_s1;

	always_ff @(posedge clk) begin
		if (ld1) begin
			speed_s1 <= motor_speed;
			head_s1  <= heading;
			goal_s1  <= heading_goal;
			rate_s1  <= body_rate;
			rgoal_s1 <= rate_goal;
		end
		if (ld.ld2) begin
			speed_s2 <= speed_s1;
		end
		if (ld.ld3) begin
			speed_s3 <= speed_s2;
		end
		if (ld.ld4) begin
			speed_s4 <= speed_s3;
		end
	end

	// errors; heading moved by a full turn to lie within half a turn of the goal
	logic signed [dpid_pkg::RATE_ERR_W-1:0]  rate_err;
	logic signed [dpid_pkg::ANGLE_ERR_W-1:0] angle_err;
	logic signed [HW-1:0] head_x, goal_x, head_w;

	assign rate_err = dpid_pkg::RATE_ERR_W'(rate_s1) - dpid_pkg::RATE_ERR_W'(rgoal_s1);
	assign head_x   = HW'(head_s1);
	assign goal_x   = {{(HW - dpid_pkg::GOAL_W){1'b0}}, goal_s1};

	always_comb begin
		priority if (head_x <= goal_x - HW'(dpid_pkg::HALF_TURN)) begin
			head_w = head_x + HW'(dpid_pkg::FULL_TURN);
		end else if (head_x > goal_x + HW'(dpid_pkg::HALF_TURN)) begin
			head_w = head_x - HW'(dpid_pkg::FULL_TURN);
		end else begin
			head_w = head_x;
		end
	end

	assign angle_err = dpid_pkg::ANGLE_ERR_W'(head_w - goal_x);

	logic signed [DW-1:0] rate_drive_s4, angle_drive_s4;

	dpid_loop #(
		.E_W(dpid_pkg::RATE_ERR_W)
	) u_rate_loop (
		.clk         (clk),
		.arst_n      (arst_n),
		.ld          (ld),
		.err         (rate_err),
		.kp          (rate_kp_q),
		.ki          (rate_ki_q),
		.kd          (rate_kd_q),
		.integ_limit (integ_lim_q),
		.drive       (rate_drive_s4)
	);

	dpid_loop #(
		.E_W(dpid_pkg::ANGLE_ERR_W)
	) u_angle_loop (
		.clk         (clk),
		.arst_n      (arst_n),
		.ld          (ld),
		.err         (angle_err),
		.kp          (angle_kp_q),
		.ki          (angle_ki_q),
		.kd          (angle_kd_q),
		.integ_limit (integ_lim_q),
		.drive       (angle_drive_s4)
	);

	// speed command: truncate toward zero to whole rpm, then clamp
	logic signed [X_W-1:0] cmd_x;
	logic signed [Q_W-1:0] cmd_q, max_s;
	logic                  round_up;

	assign cmd_x    = (X_W'(speed_s4) <<< 8) + X_W'(rate_drive_s4);
	assign round_up = cmd_x[X_W-1] && (|cmd_x[7:0]);
	assign cmd_q    = cmd_x[X_W-1:8] + {{(Q_W-1){1'b0}}, round_up};
	assign max_s    = {{(Q_W - dpid_pkg::MAXS_W){1'b0}}, max_speed_q};

	always_ff @(posedge clk) begin
		if (ld_out) begin
			rate_drive  <= rate_drive_s4;
			angle_drive <= angle_drive_s4;
			if (cmd_q > max_s) begin
				new_motor_speed <= SW'(max_s);
				speed_limited   <= 1'b1;
			end else if (cmd_q < -max_s) begin
				new_motor_speed <= SW'(-max_s);
				speed_limited   <= 1'b1;
			end else begin
				new_motor_speed <= SW'(cmd_q);
				speed_limited   <= 1'b0;
			end
		end
	end

endmodule
